// ===== hdl/rect_point_scaler_defines.svh =====
// ============================================================================
// rect_point_scaler_defines.svh
// Assertion macros shared by the rect_point_scaler RTL.
// ============================================================================
`ifndef RECT_POINT_SCALER_DEFINES_SVH
`define RECT_POINT_SCALER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RPS_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RPS_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/rps_pkg.sv =====
// ============================================================================
// rps_pkg
// Widths, register map, stage payloads and helpers of the point scaler.
// ============================================================================
`default_nettype none

package rps_pkg;

   localparam int COORD_BITS     = 16;
   localparam int QUO_BITS       = COORD_BITS - 1;
   localparam int PROD_BITS      = 2 * QUO_BITS;
   localparam int MAP_BITS       = COORD_BITS + 1;
   localparam int REQ_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((2 * MAP_BITS + 7) / 8) * 8;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [QUO_BITS-1:0]          quo_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DEST_LEFT,
      CSR_DEST_TOP,
      CSR_DEST_SPAN_X,
      CSR_DEST_SPAN_Y,
      CSR_SRC_LEFT,
      CSR_SRC_TOP,
      CSR_SRC_SPAN_X,
      CSR_SRC_SPAN_Y
   } csr_index_type;

   localparam coord_type DEST_LEFT_RESET   = coord_type'(0);
   localparam coord_type DEST_TOP_RESET    = coord_type'(0);
   localparam coord_type DEST_SPAN_X_RESET = coord_type'(256);
   localparam coord_type DEST_SPAN_Y_RESET = coord_type'(192);
   localparam coord_type SRC_LEFT_RESET    = coord_type'(0);
   localparam coord_type SRC_TOP_RESET     = coord_type'(0);
   localparam coord_type SRC_SPAN_X_RESET  = coord_type'(640);
   localparam coord_type SRC_SPAN_Y_RESET  = coord_type'(480);

   typedef struct packed {
      coord_type dest_left;
      coord_type dest_top;
      coord_type dest_span_x;
      coord_type dest_span_y;
      coord_type src_left;
      coord_type src_top;
      coord_type src_span_x;
      coord_type src_span_y;
   } cfg_type;

   // after the range check: offsets into the destination rectangle
   typedef struct packed {
      logic    in_rect;
      quo_type off_x;
      quo_type off_y;
   } front_type;

   // divider payload: partial remainder, and dividend bits becoming quotient
   typedef struct packed {
      logic    in_rect;
      quo_type rem_x;
      quo_type quo_x;
      quo_type rem_y;
      quo_type quo_y;
   } div_type;

   typedef struct packed {
      quo_type rem;
      quo_type quo;
   } div_bit_type;

   function automatic logic span_pos(input coord_type s);
      return !s[COORD_BITS-1] && (s != '0);
   endfunction

   // one restoring step: shift in next dividend bit, subtract when it fits
   function automatic div_bit_type div_bit(input quo_type rem, input quo_type quo,
                                           input quo_type d);
      logic [QUO_BITS:0] trial;
      logic [QUO_BITS:0] diff;
      logic              ge;
      div_bit_type       res;
      trial   = {rem, quo[QUO_BITS-1]};
      diff    = trial - {1'b0, d};
      ge      = trial >= {1'b0, d};
      res.rem = ge ? diff[QUO_BITS-1:0] : trial[QUO_BITS-1:0];
      res.quo = {quo[QUO_BITS-2:0], ge};
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/rect_point_scaler.sv =====
// ============================================================================
// rect_point_scaler
// Maps a destination-space point into a source rectangle, pipelined.
// ============================================================================
//  channel | dir | handshake            | content
//  req     | in  | req_tvalid/tready    | tdata: point_x, point_y
//  rsp     | out | rsp_tvalid/tready    | tdata: mapped_x, mapped_y; tuser: inside_res
//  csr     | in  | csr_we (no wait)     | csr_index, csr_wdata
//
//  One item a cycle while the output is taken; registered stages, in order:
//  range check, span product, one quotient bit per divider stage, origin add.
//  Reset clears the valid bits and loads the register defaults.
//  Each stage holds while it is full and its successor is not ready; empty stages close up.
// ============================================================================
`default_nettype none
`include "rect_point_scaler_defines.svh"

module rect_point_scaler (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [rps_pkg::REQ_DATA_BITS-1:0]     req_tdata,  // point_x, point_y
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [rps_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,  // mapped_x, mapped_y
   output logic                                       rsp_tuser,  // inside_res
   input  wire logic                                  csr_we,
   input  wire logic [rps_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [rps_pkg::COORD_BITS-1:0]        csr_wdata
);
   import rps_pkg::*;

   cfg_type              cfg_ff;
   coord_type            point_x;
   coord_type            point_y;
   logic                 stg_valid [QUO_BITS+1];
   logic                 stg_ready [QUO_BITS+1];
   div_type              stg_data  [QUO_BITS+1];
   logic                 rsp_valid_ff;
   logic                 rsp_inside_ff;
   logic [MAP_BITS-1:0]  rsp_x_ff;
   logic [MAP_BITS-1:0]  rsp_y_ff;
   logic [MAP_BITS-1:0]  map_x_in;
   logic [MAP_BITS-1:0]  map_y_in;
   div_type              last;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_left   <= DEST_LEFT_RESET;
         cfg_ff.dest_top    <= DEST_TOP_RESET;
         cfg_ff.dest_span_x <= DEST_SPAN_X_RESET;
         cfg_ff.dest_span_y <= DEST_SPAN_Y_RESET;
         cfg_ff.src_left    <= SRC_LEFT_RESET;
         cfg_ff.src_top     <= SRC_TOP_RESET;
         cfg_ff.src_span_x  <= SRC_SPAN_X_RESET;
         cfg_ff.src_span_y  <= SRC_SPAN_Y_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEST_LEFT:   cfg_ff.dest_left   <= csr_wdata;
            CSR_DEST_TOP:    cfg_ff.dest_top    <= csr_wdata;
            CSR_DEST_SPAN_X: cfg_ff.dest_span_x <= csr_wdata;
            CSR_DEST_SPAN_Y: cfg_ff.dest_span_y <= csr_wdata;
            CSR_SRC_LEFT:    cfg_ff.src_left    <= csr_wdata;
            CSR_SRC_TOP:     cfg_ff.src_top     <= csr_wdata;
            CSR_SRC_SPAN_X:  cfg_ff.src_span_x  <= csr_wdata;
            CSR_SRC_SPAN_Y:  cfg_ff.src_span_y  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign point_x = req_tdata[COORD_BITS-1:0];
   assign point_y = req_tdata[2*COORD_BITS-1:COORD_BITS];

   rps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .point_x   (point_x),
      .point_y   (point_y),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_data  (stg_data[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
      rps_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .div_x     (cfg_ff.dest_span_x[QUO_BITS-1:0]),
         .div_y     (cfg_ff.dest_span_y[QUO_BITS-1:0]),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_data   (stg_data[i]),
         .out_valid (stg_valid[i+1]),
         .out_ready (stg_ready[i+1]),
         .out_data  (stg_data[i+1])
      );
   end

   // origin add and output register
   assign last = stg_data[QUO_BITS];
   assign stg_ready[QUO_BITS] = !rsp_valid_ff || rsp_tready;

   always_comb begin
      map_x_in = {cfg_ff.src_left[COORD_BITS-1], cfg_ff.src_left} +
                 {{2{1'b0}}, last.quo_x};
      map_y_in = {cfg_ff.src_top[COORD_BITS-1], cfg_ff.src_top} +
                 {{2{1'b0}}, last.quo_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stg_ready[QUO_BITS]) begin
         rsp_valid_ff <= stg_valid[QUO_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[QUO_BITS] && stg_valid[QUO_BITS]) begin
         rsp_inside_ff <= last.in_rect;
         rsp_x_ff      <= last.in_rect ? map_x_in : '0;
         rsp_y_ff      <= last.in_rect ? map_y_in : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_inside_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_y_ff, rsp_x_ff});

   `RPS_ASSERT_IMP(a_zero_outside, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata == '0, "result outside the rectangle carries non-zero coordinates")
   `RPS_ASSERT_IMP(a_quo_range, clock, reset, stg_valid[QUO_BITS] && last.in_rect,
      (last.quo_x < cfg_ff.src_span_x[QUO_BITS-1:0]) &&
      (last.quo_y < cfg_ff.src_span_y[QUO_BITS-1:0]),
      "quotient not below source span")
   `RPS_ASSERT_IMP(a_no_stall_empty, clock, reset, !rsp_tvalid, req_tready,
      "input stalled with empty output register")

endmodule

`default_nettype wire

// ===== hdl/rps_front.sv =====
// ============================================================================
// rps_front
// Range check and offset (first stage), span product (second stage).
// ============================================================================
`default_nettype none
`include "rect_point_scaler_defines.svh"

module rps_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire rps_pkg::cfg_type   cfg,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire rps_pkg::coord_type point_x,
   input  wire rps_pkg::coord_type point_y,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output rps_pkg::div_type     out_data
);
   import rps_pkg::*;

   logic                s1_valid_ff;
   front_type           s1_ff;
   front_type           s1_in;
   logic                s2_ready;
   logic                s2_valid_ff;
   div_type             s2_ff;
   div_type             s2_in;
   logic signed [COORD_BITS:0] diff_x;
   logic signed [COORD_BITS:0] diff_y;
   logic                cfg_ok;
   logic                in_x;
   logic                in_y;
   logic [PROD_BITS-1:0] prod_x;
   logic [PROD_BITS-1:0] prod_y;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff || s2_ready;

   always_comb begin
      cfg_ok = span_pos(cfg.dest_span_x) && span_pos(cfg.dest_span_y) &&
               span_pos(cfg.src_span_x) && span_pos(cfg.src_span_y);
      diff_x = {point_x[COORD_BITS-1], point_x} - {cfg.dest_left[COORD_BITS-1], cfg.dest_left};
      diff_y = {point_y[COORD_BITS-1], point_y} - {cfg.dest_top[COORD_BITS-1], cfg.dest_top};
      in_x   = !diff_x[COORD_BITS] &&
               (diff_x < $signed({cfg.dest_span_x[COORD_BITS-1], cfg.dest_span_x}));
      in_y   = !diff_y[COORD_BITS] &&
               (diff_y < $signed({cfg.dest_span_y[COORD_BITS-1], cfg.dest_span_y}));
      s1_in.in_rect = cfg_ok && in_x && in_y;
      s1_in.off_x   = diff_x[QUO_BITS-1:0];
      s1_in.off_y   = diff_y[QUO_BITS-1:0];
   end

   always_comb begin
      prod_x        = s1_ff.off_x * cfg.src_span_x[QUO_BITS-1:0];
      prod_y        = s1_ff.off_y * cfg.src_span_y[QUO_BITS-1:0];
      s2_in.in_rect = s1_ff.in_rect;
      s2_in.rem_x   = prod_x[PROD_BITS-1:QUO_BITS];
      s2_in.quo_x   = prod_x[QUO_BITS-1:0];
      s2_in.rem_y   = prod_y[PROD_BITS-1:QUO_BITS];
      s2_in.quo_y   = prod_y[QUO_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_ff <= s1_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

   `RPS_ASSERT_NXT(a_front_take, clock, reset, in_valid && in_ready, s1_valid_ff,
      "transfer into the front stage lost")
   `RPS_ASSERT_IMP(a_front_off, clock, reset, s1_valid_ff && s1_ff.in_rect,
      (s1_ff.off_x < cfg.dest_span_x[QUO_BITS-1:0]) &&
      (s1_ff.off_y < cfg.dest_span_y[QUO_BITS-1:0]),
      "offset of an inside point not below destination span")

endmodule

`default_nettype wire

// ===== hdl/rps_div_step.sv =====
// ============================================================================
// rps_div_step
// One registered restoring-division step for both axes.
// ============================================================================
`default_nettype none
`include "rect_point_scaler_defines.svh"

module rps_div_step (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rps_pkg::quo_type div_x,
   input  wire rps_pkg::quo_type div_y,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire rps_pkg::div_type in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output rps_pkg::div_type   out_data
);
   import rps_pkg::*;

   logic        valid_ff;
   div_type     data_ff;
   div_type     data_in;
   div_bit_type step_x;
   div_bit_type step_y;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      step_x          = div_bit(in_data.rem_x, in_data.quo_x, div_x);
      step_y          = div_bit(in_data.rem_y, in_data.quo_y, div_y);
      data_in.in_rect = in_data.in_rect;
      data_in.rem_x   = step_x.rem;
      data_in.quo_x   = step_x.quo;
      data_in.rem_y   = step_y.rem;
      data_in.quo_y   = step_y.quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   `RPS_ASSERT_IMP(a_div_rem, clock, reset, valid_ff && data_ff.in_rect,
      (data_ff.rem_x < div_x) && (data_ff.rem_y < div_y),
      "partial remainder not below divisor")

endmodule

`default_nettype wire
